FILE: sv/rgco_pkg.sv
`default_nettype none
package rgco_pkg;

  localparam int IndexBits = 16;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 12;

  localparam logic [15:0] IndexMask = 16'((1 << IndexBits) - 1);

  localparam logic [7:0] CostMax     = 8'd252;
  localparam logic [7:0] CostUnknown = 8'd255;

  typedef enum logic [3:0] {
    REG_LAYER_ENABLE   = 4'd0,
    REG_CENTER_X       = 4'd1,
    REG_CENTER_Y       = 4'd2,
    REG_FALLOFF_RADIUS = 4'd3,
    REG_PEAK_STRENGTH  = 4'd4,
    REG_CELL_SIZE      = 4'd5,
    REG_GRID_ORIGIN_X  = 4'd6,
    REG_GRID_ORIGIN_Y  = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic       kill;
    logic       on_edge;
    logic [7:0] old_cost;
  } tag_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
    tag_t        tag;
  } sqrt_t;

  typedef struct packed {
    logic [54:0] rem;
    logic [53:0] dsh;
    logic [11:0] quo;
    tag_t        tag;
  } div_t;

endpackage
`default_nettype wire

FILE: sv/rgco_sqrt_cell.sv
`default_nettype none
module rgco_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  rgco_pkg::sqrt_t in_data,
  output logic           out_valid,
  output rgco_pkg::sqrt_t out_data
);
  import rgco_pkg::*;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;
  sqrt_t       nxt;

  always_comb begin
    rem_sh = {in_data.rem, in_data.rad[63:62]};
    trial  = {2'b00, in_data.root, 2'b01};
    take   = (rem_sh >= trial);
    nxt     = in_data;
    nxt.rad = {in_data.rad[61:0], 2'b00};
    if (take) begin
      nxt.rem  = 34'(rem_sh - trial);
      nxt.root = {in_data.root[30:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh[33:0];
      nxt.root = {in_data.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rgco_div_cell.sv
`default_nettype none
module rgco_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  rgco_pkg::div_t in_data,
  output logic          out_valid,
  output rgco_pkg::div_t out_data
);
  import rgco_pkg::*;

  logic take;
  div_t nxt;

  always_comb begin
    take    = (in_data.rem >= {1'b0, in_data.dsh});
    nxt     = in_data;
    nxt.dsh = {1'b0, in_data.dsh[53:1]};
    if (take) begin
      nxt.rem = in_data.rem - {1'b0, in_data.dsh};
      nxt.quo = {in_data.quo[10:0], 1'b1};
    end else begin
      nxt.quo = {in_data.quo[10:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/radial_gradient_cost_overlay_core.sv
// channel   dir  handshake             payload
// s_axis    in   s_tvalid / s_tready   s_tdata: cell_col, cell_row, old_cost
// m_axis    out  m_tvalid / m_tready   m_tdata: write_cell, new_cost
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One cell per cycle while the output register is not stalled.
// The pipeline holds the 32 root cells, the 12 divide cells and ten single stages.
// rst clears the stage valid bits and loads the register defaults.
// The whole chain stalls while the output register holds an untaken result.
`default_nettype none
module radial_gradient_cost_overlay_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cell_col[15:0], cell_row[31:16], old_cost[39:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // write_cell[0], new_cost[8:1], zero[15:9]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rgco_pkg::*;

  logic        layer_enable;
  logic [31:0] center_x, center_y, grid_origin_x, grid_origin_y, cell_size;
  logic [30:0] falloff_radius;
  logic [15:0] peak_strength;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_enable   <= 1'b1;
      center_x       <= '0;
      center_y       <= '0;
      falloff_radius <= 31'd327680;
      peak_strength  <= 16'd4096;
      cell_size      <= 32'd3277;
      grid_origin_x  <= '0;
      grid_origin_y  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LAYER_ENABLE:   layer_enable   <= cfg_data[0];
        REG_CENTER_X:       center_x       <= cfg_data;
        REG_CENTER_Y:       center_y       <= cfg_data;
        REG_FALLOFF_RADIUS: falloff_radius <= cfg_data[30:0];
        REG_PEAK_STRENGTH:  peak_strength  <= cfg_data[15:0];
        REG_CELL_SIZE:      cell_size      <= cfg_data;
        REG_GRID_ORIGIN_X:  grid_origin_x  <= cfg_data;
        REG_GRID_ORIGIN_Y:  grid_origin_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // front stages
  logic        a_v, b_v, c_v, d_v, e_v, f_v;
  logic [15:0] a_col, a_row;
  tag_t        a_tag, b_tag, c_tag, d_tag, e_tag;
  logic [47:0] b_offx, b_offy;
  logic [49:0] c_ax, c_ay;
  logic [30:0] d_ax, d_ay;
  logic [61:0] e_sqx, e_sqy, e_r2;

  logic [48:0] prod_x, prod_y;
  logic signed [49:0] dx, dy;
  logic [49:0] r_ext;
  logic        out_c;
  logic [62:0] sq;
  sqrt_t       f_data;

  always_comb begin
    prod_x = {17'b0, a_col, 1'b1} * {17'b0, cell_size};
    prod_y = {17'b0, a_row, 1'b1} * {17'b0, cell_size};
    dx = $signed({{18{grid_origin_x[31]}}, grid_origin_x}) + $signed({2'b00, b_offx})
         - $signed({{18{center_x[31]}}, center_x});
    dy = $signed({{18{grid_origin_y[31]}}, grid_origin_y}) + $signed({2'b00, b_offy})
         - $signed({{18{center_y[31]}}, center_y});
    r_ext = {19'b0, falloff_radius};
    out_c = (c_ax > r_ext) || (c_ay > r_ext);
    sq    = {1'b0, e_sqx} + {1'b0, e_sqy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0; d_v <= 1'b0; e_v <= 1'b0; f_v <= 1'b0;
    end else if (adv) begin
      a_v <= s_tvalid; b_v <= a_v; c_v <= b_v; d_v <= c_v; e_v <= d_v; f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_col <= s_tdata[15:0] & IndexMask;
      a_row <= s_tdata[31:16] & IndexMask;
      a_tag <= '{kill: !layer_enable, on_edge: 1'b0, old_cost: s_tdata[39:32]};
      b_offx <= prod_x[48:1];
      b_offy <= prod_y[48:1];
      b_tag  <= a_tag;
      c_ax   <= dx[49] ? 50'(-dx) : 50'(dx);
      c_ay   <= dy[49] ? 50'(-dy) : 50'(dy);
      c_tag  <= b_tag;
      d_ax   <= c_ax[30:0];
      d_ay   <= c_ay[30:0];
      d_tag  <= '{kill: c_tag.kill || out_c, on_edge: 1'b0, old_cost: c_tag.old_cost};
      e_sqx  <= {31'b0, d_ax} * {31'b0, d_ax};
      e_sqy  <= {31'b0, d_ay} * {31'b0, d_ay};
      e_r2   <= {31'b0, falloff_radius} * {31'b0, falloff_radius};
      e_tag  <= d_tag;
      f_data.rad  <= {1'b0, sq};
      f_data.rem  <= '0;
      f_data.root <= '0;
      f_data.tag  <= '{kill: e_tag.kill || (sq > {1'b0, e_r2}),
                       on_edge: (sq == {1'b0, e_r2}), old_cost: e_tag.old_cost};
    end
  end

  // square root chain
  logic  sq_v [0:SqrtSteps];
  sqrt_t sq_d [0:SqrtSteps];
  assign sq_v[0] = f_v;
  assign sq_d[0] = f_data;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    rgco_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .in_valid(sq_v[k]), .in_data(sq_d[k]),
      .out_valid(sq_v[k+1]), .out_data(sq_d[k+1])
    );
  end

  // scale stages
  logic        g_v, h_v, i_v;
  logic [30:0] g_rd;
  logic [46:0] h_p;
  tag_t        g_tag, h_tag;
  div_t        i_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0; h_v <= 1'b0; i_v <= 1'b0;
    end else if (adv) begin
      g_v <= sq_v[SqrtSteps]; h_v <= g_v; i_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_rd  <= falloff_radius - sq_d[SqrtSteps].root[30:0];
      g_tag <= sq_d[SqrtSteps].tag;
      h_p   <= {16'b0, g_rd} * {31'b0, peak_strength};
      h_tag <= g_tag;
      i_data.rem <= {8'b0, h_p} * {47'b0, CostMax};
      i_data.dsh <= {falloff_radius, 23'b0};
      i_data.quo <= '0;
      i_data.tag <= h_tag;
    end
  end

  // divide chain
  logic dv_v [0:DivSteps];
  div_t dv_d [0:DivSteps];
  assign dv_v[0] = i_v;
  assign dv_d[0] = i_data;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    rgco_div_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .in_valid(dv_v[k]), .in_data(dv_d[k]),
      .out_valid(dv_v[k+1]), .out_data(dv_d[k+1])
    );
  end

  // output register
  tag_t       o_tag;
  logic [7:0] cost;
  logic       wr;

  always_comb begin
    o_tag = dv_d[DivSteps].tag;
    if (o_tag.on_edge) begin
      cost = '0;
    end else if (dv_d[DivSteps].quo > {4'b0, CostMax}) begin
      cost = CostMax;
    end else begin
      cost = dv_d[DivSteps].quo[7:0];
    end
    wr = !o_tag.kill && ((o_tag.old_cost == CostUnknown) || (cost > o_tag.old_cost));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_v[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {7'b0, (wr ? cost : 8'd0), wr};
    end
  end

`ifndef SYNTHESIS
  a_cost_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:1] <= CostMax))
    else $error("cost above maximum");
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'd0))
    else $error("cost on a cell not written");
  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    ($past(dv_v[DivSteps] && adv) && !$past(rst)) |-> m_tvalid)
    else $error("result lost at output register");
`endif

endmodule
`default_nettype wire
